// ----- hw/rtl/apr_pkg.sv -----
// Shared word types and constants for the aging page replacement block.
package apr_pkg;

  localparam int KEY_W      = 16;
  localparam int AGE_W      = 8;
  localparam int OCC_W      = 5;
  localparam int CAP_W      = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_AGE = 8'd1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET    = 5'd16;
  localparam logic [AGE_W-1:0] INITIAL_AGE_RESET = 8'd128;
  localparam logic [AGE_W-1:0] AGE_TOP_BIT       = 8'h80;

  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] page_key;
  } in_word_t;

  typedef struct packed {
    logic             hit;
    logic [AGE_W-1:0] age;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

endpackage

// ----- hw/rtl/aging_page_replacement_top.sv -----
// Top level of the aging page replacement table: sequencer, scan unit and registers.
//
//   channel | signals                                   | word
//   --------+-------------------------------------------+----------------------------
//   in      | in_valid, in_ready, in_data               | func, page_key
//   out     | out_valid, out_ready, out_data            | hit, age, evicted, ...
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register index, write data
//
// A tick makes one pass through the entry RAM, one entry per cycle.
// An access makes the same pass, and a second one when an insertion or an eviction
// needs the insertion ranks renumbered.
// The single RAM read port and the one shared compare unit set this pace.
// Reset is synchronous; valid bits live in flip-flops, so no clearing pass follows reset.
// A finished result waits in the output register; a new word is accepted meanwhile,
// and its result is held back until the previous one is taken.
module aging_page_replacement_top #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  apr_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output apr_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [apr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import apr_pkg::*;

  // Only the low bits of a key that the page number field can carry are stored.
  localparam int KB   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RB   = AW;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int XW   = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef struct packed {
    logic [KB-1:0]    key;
    logic [AGE_W-1:0] age;
    logic [RB-1:0]    rank;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  // How the second pass renumbers the ranks.
  typedef enum logic [1:0] {
    MODE_REMOVE,
    MODE_REPLACE,
    MODE_INSERT
  } mode_t;

  state_t state;
  mode_t  mode;

  logic [CAP_W-1:0] capacity;
  logic [AGE_W-1:0] initial_age;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0] count;

  logic          op_tick;
  logic [KB-1:0] op_key;

  // Pass sequencing: cnt issues RAM reads, pidx tags the data coming back.
  logic          issuing;
  logic [AW-1:0] cnt;
  logic          pv;
  logic [AW-1:0] pidx;
  logic          pass_last;

  // Results of the scan pass.
  logic             match_found;
  logic [AGE_W-1:0] match_age;
  logic             victim_found;
  logic [AW-1:0]    victim_idx;
  logic [AGE_W-1:0] victim_age;
  logic [RB-1:0]    victim_rank;
  logic [KB-1:0]    victim_key;
  logic             free_found;
  logic [AW-1:0]    free_idx;

  // Second-pass controls.
  logic [AW-1:0] slot;
  logic [RB-1:0] thr;

  // Result fields waiting for the output register.
  logic             res_hit;
  logic [AGE_W-1:0] res_age;
  logic             res_ev;
  logic [KEY_W-1:0] res_ev_key;

  entry_t rd_entry;
  entry_t wr_entry;
  logic   ram_we;

  logic             ent_valid;
  logic             key_match;
  logic [AGE_W-1:0] ent_age;
  logic             better;
  logic [XW-1:0]    count_x;
  logic [XW-1:0]    cap_x;

  apr_entry_ram #(
    .DEPTH(ENTRIES),
    .AW   (AW),
    .WIDTH($bits(entry_t))
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pidx),
    .wdata(wr_entry),
    .raddr(cnt),
    .rdata(rd_entry)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign pass_last = pv && (pidx == LAST);
  assign count_x   = XW'(count);
  assign cap_x     = XW'(capacity);

  // Shared compare unit: key match, the hit update and the victim comparison for the
  // entry that the RAM returns this cycle. The age used is the one after a hit update.
  always_comb begin
    ent_valid = valid[pidx];
    key_match = ent_valid && (rd_entry.key == op_key);
    ent_age   = key_match ? (AGE_TOP_BIT | (rd_entry.age >> 1)) : rd_entry.age;
    better    = ent_valid && (!victim_found || (ent_age < victim_age) ||
                ((ent_age == victim_age) && (rd_entry.rank < victim_rank)));
  end

  // Write-back of the entry just read.
  always_comb begin
    ram_we   = 1'b0;
    wr_entry = rd_entry;
    if (pv) begin
      unique case (state)
        S_SCAN: begin
          if (op_tick) begin
            ram_we       = ent_valid;
            wr_entry.age = rd_entry.age >> 1;
          end else begin
            ram_we       = key_match;
            wr_entry.age = ent_age;
          end
        end
        S_UPDATE: begin
          if ((pidx == slot) && (mode != MODE_REMOVE)) begin
            ram_we        = 1'b1;
            wr_entry.key  = op_key;
            wr_entry.age  = initial_age;
            wr_entry.rank = '0;
          end else if (ent_valid) begin
            ram_we = 1'b1;
            case (mode)
              MODE_REMOVE: begin
                if (rd_entry.rank > thr) begin
                  wr_entry.rank = RB'(rd_entry.rank - 1'b1);
                end
              end
              MODE_REPLACE: begin
                if (rd_entry.rank < thr) begin
                  wr_entry.rank = RB'(rd_entry.rank + 1'b1);
                end
              end
              default: begin
                wr_entry.rank = RB'(rd_entry.rank + 1'b1);
              end
            endcase
          end
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      count       <= '0;
      capacity    <= CAPACITY_RESET;
      initial_age <= INITIAL_AGE_RESET;
      out_valid   <= 1'b0;
      issuing     <= 1'b0;
      pv          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CAPACITY:    capacity    <= cfg_data[CAP_W-1:0];
          REG_INITIAL_AGE: initial_age <= cfg_data[AGE_W-1:0];
          default: ;
        endcase
      end

      // A word leaving while the next result is ready is replaced in the same cycle.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      pv <= issuing;
      if (issuing) begin
        pidx <= cnt;
        if (cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_tick      <= (in_data.func == FUNC_TICK);
            op_key       <= in_data.page_key[KB-1:0];
            match_found  <= 1'b0;
            victim_found <= 1'b0;
            free_found   <= 1'b0;
            cnt          <= '0;
            issuing      <= 1'b1;
            state        <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pv && !op_tick) begin
            if (key_match) begin
              match_found <= 1'b1;
              match_age   <= ent_age;
            end
            if (better) begin
              victim_found <= 1'b1;
              victim_idx   <= pidx;
              victim_age   <= ent_age;
              victim_rank  <= rd_entry.rank;
              victim_key   <= rd_entry.key;
            end
            if (!ent_valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pidx;
            end
          end
          if (pass_last) begin
            if (op_tick) begin
              res_hit    <= 1'b0;
              res_age    <= '0;
              res_ev     <= 1'b0;
              res_ev_key <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          res_hit    <= match_found;
          res_ev     <= 1'b0;
          res_ev_key <= '0;
          state      <= S_DONE;
          if (match_found) begin
            res_age <= match_age;
            // A lowered capacity lets a hit evict one page, possibly the one just hit.
            if ((count_x > cap_x) && victim_found) begin
              res_ev            <= 1'b1;
              res_ev_key        <= KEY_W'(victim_key);
              valid[victim_idx] <= 1'b0;
              count             <= count - 1'b1;
              mode              <= MODE_REMOVE;
              thr               <= victim_rank;
              cnt               <= '0;
              issuing           <= 1'b1;
              state             <= S_UPDATE;
            end
          end else begin
            res_age <= initial_age;
            if ((count_x >= cap_x) || (count == CW'(ENTRIES))) begin
              res_ev <= 1'b1;
              if (victim_found && (victim_age < initial_age)) begin
                // The victim's slot takes the new page.
                res_ev_key <= KEY_W'(victim_key);
                mode       <= MODE_REPLACE;
                slot       <= victim_idx;
                thr        <= victim_rank;
                cnt        <= '0;
                issuing    <= 1'b1;
                state      <= S_UPDATE;
              end else begin
                // The new page is no younger than the oldest resident (or none is resident) and never enters the table.
                res_ev_key <= KEY_W'(op_key);
              end
            end else begin
              valid[free_idx] <= 1'b1;
              count           <= count + 1'b1;
              mode            <= MODE_INSERT;
              slot            <= free_idx;
              cnt             <= '0;
              issuing         <= 1'b1;
              state           <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (pass_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.hit         <= res_hit;
            out_data.age         <= res_age;
            out_data.evicted     <= res_ev;
            out_data.evicted_key <= res_ev_key;
            out_data.occupancy   <= OCC_W'(count);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == count)
    else $error("resident count disagrees with the valid bits");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN))
    else $error("accepted word did not start a scan pass");

  a_tick_skips_decide: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> !op_tick)
    else $error("tick reached the access decision step");

  a_hit_age_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit) |-> out_data.age[AGE_W-1])
    else $error("hit result without the top age bit set");

  a_no_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.evicted) |-> (out_data.evicted_key == '0))
    else $error("evicted key nonzero without an eviction");
`endif

endmodule

// ----- hw/rtl/apr_entry_ram.sv -----
// Entry storage: one write port and one registered read port.
module apr_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 28
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
